@@ hw/rtl/svg_pkg.sv @@
// Shared types, walk phases and the sequencer control store for the sphere
// voxel generator. Used by svg_walk and sphere_voxel_generator; depends on nothing.
package svg_pkg;

  localparam int RADIUS_W = 8;   // width of the radius register
  localparam int COORD_W  = 9;   // width of an emitted coordinate
  localparam int WALK_W   = 10;  // signed walk coordinates (one step below zero)
  localparam int ERR_W    = 12;  // signed midpoint decision variable
  localparam int TMP_W    = 14;  // signed width for doubled error sums

  typedef enum logic [1:0] {
    PH_DONE  = 2'd0,
    PH_OUTER = 2'd1,
    PH_INNER = 2'd2,
    PH_SPAN  = 2'd3
  } walk_phase_t;

  // Program addresses of the sequencer.
  typedef enum logic [2:0] {
    PC_IDLE = 3'd0,
    PC_INIT = 3'd1,
    PC_ADV1 = 3'd2,
    PC_CAP  = 3'd3,
    PC_ADV2 = 3'd4,
    PC_PUT  = 3'd5
  } pc_t;

  // A step holds its address until its condition is true.
  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_IN_TAKE  = 2'd1,
    COND_WALK_HIT = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_t;

  typedef struct packed {
    pc_t   next_pc;        // successor when the condition holds
    pc_t   branch_pc;      // successor when branching on restart
    cond_t hold_until;
    logic  branch_restart; // take branch_pc if the accepted item asks for restart
    logic  in_open;        // input channel may accept in this step
    logic  init;           // load the outer walk from the radius
    logic  step;           // run one walk action this cycle
    logic  capture;        // copy the look-ahead voxel into the result holding regs
    logic  load_out;       // move the held result into the output register
  } ucode_t;

  typedef struct packed {
    logic init;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic               hit;  // this walk action ends the search for a voxel
    logic               ok;   // look-ahead voxel is present
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } walk_stat_t;

  // Control store. A plain request runs IDLE, ADV2, PUT; a restart runs
  // IDLE, INIT, ADV1, CAP, ADV2, PUT.
  function automatic ucode_t ucode_rom(input pc_t addr);
    ucode_t w;
    w = ucode_t'('0);
    w.next_pc   = PC_IDLE;
    w.branch_pc = PC_IDLE;
    w.hold_until = COND_ALWAYS;
    case (addr)
      PC_IDLE: begin
        w.hold_until     = COND_IN_TAKE;
        w.in_open        = 1'b1;
        w.capture        = 1'b1;
        w.branch_restart = 1'b1;
        w.branch_pc      = PC_INIT;
        w.next_pc        = PC_ADV2;
      end
      PC_INIT: begin
        w.init    = 1'b1;
        w.next_pc = PC_ADV1;
      end
      PC_ADV1: begin
        w.hold_until = COND_WALK_HIT;
        w.step       = 1'b1;
        w.next_pc    = PC_CAP;
      end
      PC_CAP: begin
        w.capture = 1'b1;
        w.next_pc = PC_ADV2;
      end
      PC_ADV2: begin
        w.hold_until = COND_WALK_HIT;
        w.step       = 1'b1;
        w.next_pc    = PC_PUT;
      end
      PC_PUT: begin
        w.hold_until = COND_OUT_FREE;
        w.load_out   = 1'b1;
        w.next_pc    = PC_IDLE;
      end
      default: begin
        w.next_pc = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/svg_walk.sv @@
// Walk datapath: outer and inner midpoint walks, span counter and the
// look-ahead voxel register. Depends on svg_pkg.
module svg_walk (
  input  logic                           clk,
  input  logic                           rst,
  input  svg_pkg::walk_ctrl_t            ctrl,
  input  logic [svg_pkg::RADIUS_W-1:0]   radius_init,
  output svg_pkg::walk_stat_t            stat
);

  localparam int WW = svg_pkg::WALK_W;
  localparam int EW = svg_pkg::ERR_W;
  localparam int TW = svg_pkg::TMP_W;
  localparam int CW = svg_pkg::COORD_W;

  svg_pkg::walk_phase_t walk_phase, walk_phase_next;

  logic signed [WW-1:0] outer_x, outer_x_next, outer_y, outer_y_next;
  logic signed [EW-1:0] outer_error, outer_error_next;
  logic signed [WW-1:0] slice_x, slice_x_next, slice_z, slice_z_next, slice_height,
                        slice_height_next;
  logic signed [EW-1:0] slice_error, slice_error_next;
  logic signed [WW-1:0] span_x, span_x_next, span_z, span_z_next, span_k, span_k_next;
  logic                 span_phase, span_phase_next, span_mirror, span_mirror_next;
  logic                 ahead_ok, ahead_ok_next;
  logic [CW-1:0]        ahead_x, ahead_x_next, ahead_y, ahead_y_next, ahead_z, ahead_z_next;
  logic                 hit;

  logic signed [TW-1:0] oe, ox, oy, o_t1, o_t2, o_diag, o_horz, o_vert;
  logic signed [TW-1:0] se, sx, sy, s_t1, s_t2, s_diag, s_horz, s_vert;
  logic signed [WW-1:0] span_y;

  always_comb begin
    oe = TW'(outer_error);
    ox = TW'(outer_x);
    oy = TW'(outer_y);
    o_t1   = (oe <<< 1) + (oy <<< 1) - TW'(1);
    o_t2   = (oe <<< 1) - (ox <<< 1) - TW'(1);
    o_diag = oe + (ox <<< 1) - (oy <<< 1) + TW'(6);
    o_horz = oe + (ox <<< 1) + TW'(3);
    o_vert = oe - (oy <<< 1) + TW'(3);

    se = TW'(slice_error);
    sx = TW'(slice_x);
    sy = TW'(slice_z);
    s_t1   = (se <<< 1) + (sy <<< 1) - TW'(1);
    s_t2   = (se <<< 1) - (sx <<< 1) - TW'(1);
    s_diag = se + (sx <<< 1) - (sy <<< 1) + TW'(6);
    s_horz = se + (sx <<< 1) + TW'(3);
    s_vert = se - (sy <<< 1) + TW'(3);

    span_y = span_phase ? -slice_height : slice_height;
  end

  always_comb begin
    walk_phase_next   = walk_phase;
    outer_x_next      = outer_x;
    outer_y_next      = outer_y;
    outer_error_next  = outer_error;
    slice_x_next      = slice_x;
    slice_z_next      = slice_z;
    slice_error_next  = slice_error;
    slice_height_next = slice_height;
    span_x_next       = span_x;
    span_z_next       = span_z;
    span_k_next       = span_k;
    span_phase_next   = span_phase;
    span_mirror_next  = span_mirror;
    ahead_ok_next     = ahead_ok;
    ahead_x_next      = ahead_x;
    ahead_y_next      = ahead_y;
    ahead_z_next      = ahead_z;
    hit               = 1'b0;

    if (ctrl.init) begin
      outer_x_next     = '0;
      outer_y_next     = WW'(radius_init);
      outer_error_next = EW'(TW'(2) - (TW'(radius_init) <<< 1));
      walk_phase_next  = svg_pkg::PH_OUTER;
    end else if (ctrl.step) begin
      case (walk_phase)
        svg_pkg::PH_OUTER: begin
          if (outer_y < 0) begin
            walk_phase_next = svg_pkg::PH_DONE;
          end else begin
            // Every branch but the horizontal one selects a slice.
            if (outer_error < 0 && !(o_t1 > 0)) begin
              outer_x_next     = outer_x + WW'(1);
              outer_error_next = o_horz[EW-1:0];
            end else begin
              if (outer_error > 0 && o_t2 > 0) begin
                outer_y_next     = outer_y - WW'(1);
                outer_error_next = o_vert[EW-1:0];
              end else begin
                outer_x_next     = outer_x + WW'(1);
                outer_y_next     = outer_y - WW'(1);
                outer_error_next = o_diag[EW-1:0];
              end
              slice_x_next      = '0;
              slice_z_next      = outer_x;
              slice_error_next  = EW'(TW'(2) - (ox <<< 1));
              slice_height_next = outer_y;
              span_x_next       = '0;
              span_z_next       = outer_x;
              span_k_next       = -outer_x;
              span_phase_next   = 1'b0;
              span_mirror_next  = 1'b0;
              walk_phase_next   = svg_pkg::PH_SPAN;
            end
          end
        end
        svg_pkg::PH_INNER: begin
          if (slice_z < 0) begin
            walk_phase_next = svg_pkg::PH_OUTER;
          end else if (slice_error > 0 && !(slice_error < 0) && s_t2 > 0) begin
            // Step in z alone: no span.
            slice_z_next     = slice_z - WW'(1);
            slice_error_next = s_vert[EW-1:0];
          end else begin
            if (slice_error < 0 && !(s_t1 > 0)) begin
              slice_x_next     = slice_x + WW'(1);
              slice_error_next = s_horz[EW-1:0];
              span_x_next      = slice_x + WW'(1);
              span_z_next      = slice_z;
              span_k_next      = -slice_z;
            end else begin
              slice_x_next     = slice_x + WW'(1);
              slice_z_next     = slice_z - WW'(1);
              slice_error_next = s_diag[EW-1:0];
              span_x_next      = slice_x + WW'(1);
              span_z_next      = slice_z - WW'(1);
              span_k_next      = WW'(1) - slice_z;
            end
            span_phase_next  = 1'b0;
            span_mirror_next = 1'b1;
            walk_phase_next  = svg_pkg::PH_SPAN;
          end
        end
        svg_pkg::PH_SPAN: begin
          if (span_k <= span_z) begin
            hit           = 1'b1;
            ahead_ok_next = 1'b1;
            ahead_x_next  = span_x[CW-1:0];
            ahead_y_next  = span_y[CW-1:0];
            ahead_z_next  = span_k[CW-1:0];
            span_k_next   = span_k + WW'(1);
          end else if (!span_phase && slice_height != 0) begin
            span_phase_next = 1'b1;
            span_k_next     = -span_z;
          end else if (span_mirror) begin
            span_x_next      = -span_x;
            span_k_next      = -span_z;
            span_phase_next  = 1'b0;
            span_mirror_next = 1'b0;
          end else begin
            walk_phase_next = svg_pkg::PH_INNER;
          end
        end
        default: begin
          hit             = 1'b1;
          ahead_ok_next   = 1'b0;
          walk_phase_next = svg_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase <= svg_pkg::PH_DONE;
      ahead_ok   <= 1'b0;
    end else begin
      walk_phase <= walk_phase_next;
      ahead_ok   <= ahead_ok_next;
    end
    outer_x      <= outer_x_next;
    outer_y      <= outer_y_next;
    outer_error  <= outer_error_next;
    slice_x      <= slice_x_next;
    slice_z      <= slice_z_next;
    slice_error  <= slice_error_next;
    slice_height <= slice_height_next;
    span_x       <= span_x_next;
    span_z       <= span_z_next;
    span_k       <= span_k_next;
    span_phase   <= span_phase_next;
    span_mirror  <= span_mirror_next;
    ahead_x      <= ahead_x_next;
    ahead_y      <= ahead_y_next;
    ahead_z      <= ahead_z_next;
  end

  assign stat.hit = hit;
  assign stat.ok  = ahead_ok;
  assign stat.x   = ahead_x;
  assign stat.y   = ahead_y;
  assign stat.z   = ahead_z;

endmodule

@@ hw/rtl/sphere_voxel_generator.sv @@
// Top level of the sphere voxel generator: microcoded sequencer, result
// holding registers and output register. Depends on svg_pkg and svg_walk.
//
// Usage: each transaction on the input channel (in_valid, in_stall, restart)
// returns exactly one transaction on the output channel (out_valid,
// out_stall, voxel_x/y/z, valid_res, last_voxel). With restart high the
// block starts a new sphere from the radius register (cfg_we, cfg_wdata);
// with restart low it returns the next voxel. Once the sphere is
// finished, results carry valid_res low and zero coordinates.
// The block keeps one voxel of look-ahead, so last_voxel is known when a
// voxel is returned. When the next voxel lies in the same span, a plain
// request runs the idle step that accepts it, one walk action and one step
// that loads the output register; no new request is taken until the block
// is back in its idle step. Every silent walk action (a step that selects
// no slice or emits no span, a span pass that ends) keeps the walk step
// waiting. A restart adds the load, first-voxel and capture steps plus the
// silent steps before the first voxel.
// The input accepts only in the idle step; a waiting result does not block
// it, but the next result waits in the sequencer until out_stall drops.
// Reset leaves the sphere finished, the output empty and the radius zero.
module sphere_voxel_generator #(
  parameter int MAX_RADIUS = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [svg_pkg::RADIUS_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [svg_pkg::COORD_W-1:0]   voxel_x,
  output logic [svg_pkg::COORD_W-1:0]   voxel_y,
  output logic [svg_pkg::COORD_W-1:0]   voxel_z,
  output logic                          valid_res,
  output logic                          last_voxel
);

  localparam int RW = svg_pkg::RADIUS_W;
  localparam int CW = svg_pkg::COORD_W;

  // Configuration register.
  logic [RW-1:0] radius;
  logic [RW-1:0] radius_sat;

  // Sequencer.
  svg_pkg::pc_t       pc, pc_next;
  svg_pkg::ucode_t    uc;
  logic               go;
  logic               in_take;
  logic               out_free;

  // Walk interface.
  svg_pkg::walk_ctrl_t walk_ctrl;
  svg_pkg::walk_stat_t walk_stat;

  // Result held between capture and output load.
  logic          res_valid;
  logic [CW-1:0] res_x, res_y, res_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // The radius saturates to the configured maximum.
  assign radius_sat = (int'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius;

  assign uc       = svg_pkg::ucode_rom(pc);
  assign in_stall = !uc.in_open;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (uc.hold_until)
      svg_pkg::COND_ALWAYS:   go = 1'b1;
      svg_pkg::COND_IN_TAKE:  go = in_take;
      svg_pkg::COND_WALK_HIT: go = walk_stat.hit;
      svg_pkg::COND_OUT_FREE: go = out_free;
      default:                go = 1'b1;
    endcase
    if (!go) begin
      pc_next = pc;
    end else if (uc.branch_restart && restart) begin
      pc_next = uc.branch_pc;
    end else begin
      pc_next = uc.next_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= svg_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign walk_ctrl.init = uc.init;
  assign walk_ctrl.step = uc.step;

  svg_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (walk_ctrl),
    .radius_init (radius_sat),
    .stat        (walk_stat)
  );

  // Capture takes the look-ahead voxel before the walk replaces it. A missing
  // voxel becomes an all-zero result.
  always_ff @(posedge clk) begin
    if (uc.capture && go) begin
      res_valid <= walk_stat.ok;
      res_x     <= walk_stat.ok ? walk_stat.x : '0;
      res_y     <= walk_stat.ok ? walk_stat.y : '0;
      res_z     <= walk_stat.ok ? walk_stat.z : '0;
    end
  end

  // Output register. The walk has already refilled the look-ahead, so a
  // given voxel is the last one when no voxel follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.load_out && go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (uc.load_out && go) begin
      voxel_x    <= res_x;
      voxel_y    <= res_y;
      voxel_z    <= res_z;
      valid_res  <= res_valid;
      last_voxel <= res_valid && !walk_stat.ok;
    end
  end

  // An accepted transaction always leaves the idle step.
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |=> pc != svg_pkg::PC_IDLE)
    else $error("sequencer stayed idle after an input transaction");

  // A loaded result appears on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (uc.load_out && go) |=> out_valid)
    else $error("loaded result not presented");

  // The final-voxel flag only accompanies a real voxel.
  a_last_needs_voxel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_voxel) |-> valid_res)
    else $error("last_voxel set on a result without a voxel");

  // A result without a voxel carries zero coordinates.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (voxel_x == '0 && voxel_y == '0 && voxel_z == '0 && !last_voxel))
    else $error("empty result with nonzero fields");

endmodule

@@ tb/sphere_voxel_checker.sv @@
// Checker for the sphere voxel generator: watches the radius register, both
// channels, predicts each voxel and compares it. Depends on svg_pkg.
module sphere_voxel_checker #(
  parameter int MAX_RADIUS = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [svg_pkg::RADIUS_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         restart,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [svg_pkg::COORD_W-1:0]  voxel_x,
  input  logic [svg_pkg::COORD_W-1:0]  voxel_y,
  input  logic [svg_pkg::COORD_W-1:0]  voxel_z,
  input  logic                         valid_res,
  input  logic                         last_voxel,
  output int                           mismatches,
  output int                           voxels_owed
);

  localparam int FW = svg_pkg::COORD_W + 1;

  typedef struct packed {
    logic [svg_pkg::COORD_W-1:0] x;
    logic [svg_pkg::COORD_W-1:0] y;
    logic [svg_pkg::COORD_W-1:0] z;
    logic                        present;
    logic                        last;
  } voxel_t;

  voxel_t voxels_due[$];
  voxel_t want;

  // Model of the sphere walk, one voxel ahead of what has been handed out.
  logic [svg_pkg::RADIUS_W-1:0] radius_q;
  int ring_x, ring_y, ring_err;           // outer circle walk over (x, y)
  int disc_x, disc_z, disc_err, disc_y;   // inner circle walk of one slice
  int row_x, row_z, row_k;                // current span
  bit row_lower, row_mirror;
  svg_pkg::walk_phase_t walk;
  bit ahead_ok;
  int ahead_x, ahead_y, ahead_z;

  function automatic void clear_walk();
    radius_q = '0;
    ring_x = 0; ring_y = 0; ring_err = 0;
    disc_x = 0; disc_z = 0; disc_err = 0; disc_y = 0;
    row_x = 0; row_z = 0; row_k = 0;
    row_lower = 1'b0; row_mirror = 1'b0;
    walk = svg_pkg::PH_DONE;
    ahead_ok = 1'b0;
    ahead_x = 0; ahead_y = 0; ahead_z = 0;
  endfunction

  function automatic void open_row(input int x, input int z, input bit mirror);
    row_x = x;
    row_z = z;
    row_k = -z;
    row_lower = 1'b0;
    row_mirror = mirror;
    walk = svg_pkg::PH_SPAN;
  endfunction

  // Horizontal steps with a negative error and a failed corner test pick no slice.
  function automatic void ring_step();
    int r, y;
    bit take;
    r = ring_x;
    y = ring_y;
    take = 1'b1;
    if (ring_err < 0) begin
      if (2 * ring_err + 2 * ring_y - 1 > 0) begin
        ring_x++; ring_y--;
        ring_err += 2 * ring_x - 2 * ring_y + 2;
      end else begin
        take = 1'b0;
        ring_x++;
        ring_err += 2 * ring_x + 1;
      end
    end else if (ring_err > 0 && 2 * ring_err - 2 * ring_x - 1 > 0) begin
      ring_y--;
      ring_err += -2 * ring_y + 1;
    end else begin
      ring_x++; ring_y--;
      ring_err += 2 * ring_x - 2 * ring_y + 2;
    end
    if (take) begin
      disc_x = 0;
      disc_z = r;
      disc_err = 2 * (1 - r);
      disc_y = y;
      open_row(0, r, 1'b0);
    end
  endfunction

  // Vertical steps of the slice walk open no span.
  function automatic void disc_step();
    bit emit;
    emit = 1'b1;
    if (disc_err < 0) begin
      if (2 * disc_err + 2 * disc_z - 1 > 0) begin
        disc_x++; disc_z--;
        disc_err += 2 * disc_x - 2 * disc_z + 2;
      end else begin
        disc_x++;
        disc_err += 2 * disc_x + 1;
      end
    end else if (disc_err > 0 && 2 * disc_err - 2 * disc_x - 1 > 0) begin
      emit = 1'b0;
      disc_z--;
      disc_err += -2 * disc_z + 1;
    end else begin
      disc_x++; disc_z--;
      disc_err += 2 * disc_x - 2 * disc_z + 2;
    end
    if (emit)
      open_row(disc_x, disc_z, 1'b1);
  endfunction

  function automatic bit walk_to_voxel(output int vx, output int vy, output int vz);
    vx = 0;
    vy = 0;
    vz = 0;
    while (1'b1) begin
      case (walk)
        svg_pkg::PH_OUTER: begin
          if (ring_y < 0) walk = svg_pkg::PH_DONE;
          else ring_step();
        end
        svg_pkg::PH_INNER: begin
          if (disc_z < 0) walk = svg_pkg::PH_OUTER;
          else disc_step();
        end
        svg_pkg::PH_SPAN: begin
          if (row_k <= row_z) begin
            vx = row_x;
            vy = row_lower ? -disc_y : disc_y;
            vz = row_k;
            row_k++;
            return 1'b1;
          end
          if (!row_lower && disc_y != 0) begin
            row_lower = 1'b1;
            row_k = -row_z;
          end else if (row_mirror) begin
            open_row(-row_x, row_z, 1'b0);
          end else begin
            walk = svg_pkg::PH_INNER;
          end
        end
        default: begin
          walk = svg_pkg::PH_DONE;
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic voxel_t next_voxel(input logic fresh);
    voxel_t v;
    int r;
    v = '0;
    if (fresh) begin
      r = int'(radius_q);
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      ring_x = 0;
      ring_y = r;
      ring_err = 2 * (1 - r);
      walk = svg_pkg::PH_OUTER;
      ahead_ok = walk_to_voxel(ahead_x, ahead_y, ahead_z);
    end
    if (ahead_ok) begin
      v.x = ahead_x[svg_pkg::COORD_W-1:0];
      v.y = ahead_y[svg_pkg::COORD_W-1:0];
      v.z = ahead_z[svg_pkg::COORD_W-1:0];
      v.present = 1'b1;
      ahead_ok = walk_to_voxel(ahead_x, ahead_y, ahead_z);
      v.last = !ahead_ok;
    end
    return v;
  endfunction

  task automatic check_field(input string field, input logic signed [FW-1:0] exp_val,
                             input logic signed [FW-1:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, exp_val, got_val);
    end
  endtask

  // The output side is handled before the input side so that a stray result
  // is never matched against a request accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      voxels_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we)
        radius_q = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (voxels_due.size() == 0) begin
          mismatches++;
          $display("%0t: voxel expected none, actual x=%0d y=%0d z=%0d valid=%b last=%b",
                   $time, $signed(voxel_x), $signed(voxel_y), $signed(voxel_z),
                   valid_res, last_voxel);
        end else begin
          want = voxels_due.pop_front();
          check_field("voxel_x", FW'($signed(want.x)), FW'($signed(voxel_x)));
          check_field("voxel_y", FW'($signed(want.y)), FW'($signed(voxel_y)));
          check_field("voxel_z", FW'($signed(want.z)), FW'($signed(voxel_z)));
          check_field("valid_res", FW'(want.present), FW'(valid_res));
          check_field("last_voxel", FW'(want.last), FW'(last_voxel));
        end
      end
      if (in_valid && !in_stall)
        voxels_due.insert(voxels_due.size(), next_voxel(restart));
    end
    voxels_owed = voxels_due.size();
  end

endmodule

@@ tb/sphere_voxel_generator_test.sv @@
// Top of the sphere voxel generator testbench: clock, reset, request and
// radius stimulus, output stall, verdict. Depends on svg_pkg and sphere_voxel_checker.
module sphere_voxel_generator_test;

  localparam int MAX_RADIUS  = 255;
  localparam int RW          = svg_pkg::RADIUS_W;
  localparam int RANDOM_REQS = 626;
  // The limit leaves a wide margin above what a slow correct run needs,
  // even with heavy stalls on both sides.
  localparam int CYCLE_LIMIT = 600000;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_we    = 1'b0;
  logic [RW-1:0]                cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  logic                         restart   = 1'b0;
  logic                         out_stall = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [svg_pkg::COORD_W-1:0]  voxel_x;
  logic [svg_pkg::COORD_W-1:0]  voxel_y;
  logic [svg_pkg::COORD_W-1:0]  voxel_z;
  logic                         valid_res;
  logic                         last_voxel;

  int mismatches;
  int voxels_owed;
  int cycles         = 0;
  int requests_sent  = 0;
  // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  sphere_voxel_generator #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .voxel_x   (voxel_x),
    .voxel_y   (voxel_y),
    .voxel_z   (voxel_z),
    .valid_res (valid_res),
    .last_voxel(last_voxel)
  );

  sphere_voxel_checker #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .voxel_x    (voxel_x),
    .voxel_y    (voxel_y),
    .voxel_z    (voxel_z),
    .valid_res  (valid_res),
    .last_voxel (last_voxel),
    .mismatches (mismatches),
    .voxels_owed(voxels_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver decides its stall once per cycle at the falling edge, so the
  // stall pattern is independent of where the block is in its walk.
  always @(negedge clk) begin
    out_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // One request transaction. The sender may idle first; while idle the
  // restart line carries noise, since the block must ignore it then. Once
  // valid is raised the payload holds until the block takes it.
  task automatic ask_voxel(input logic fresh);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      restart  = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid = 1'b1;
    restart  = fresh;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    restart  = 1'($urandom_range(1));
    requests_sent++;
  endtask

  // Hold the sender until every voxel asked for has come back, then let the
  // block settle in its idle step.
  task automatic wait_all_voxels();
    while (voxels_owed != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // The radius register is written only while the block is idle.
  task automatic load_radius(input logic [RW-1:0] r);
    wait_all_voxels();
    cfg_we    = 1'b1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = RW'($urandom_range(255));
  endtask

  initial begin
    int target;
    int phase;
    int n;
    logic [RW-1:0] rad;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Requests before any sphere was started must come back empty.
    ask_voxel(1'b0);
    ask_voxel(1'b0);

    // Radius zero gives the lone center voxel, then empty results.
    load_radius('0);
    ask_voxel(1'b1);
    ask_voxel(1'b0);
    ask_voxel(1'b0);

    // Radius one has seven voxels; run past its end into empty results.
    load_radius(8'd1);
    ask_voxel(1'b1);
    repeat (9) ask_voxel(1'b0);

    // Largest radius, abandoned mid-sphere by restarts, also back to back.
    load_radius(8'd255);
    ask_voxel(1'b1);
    repeat (3) ask_voxel(1'b0);
    ask_voxel(1'b1);
    ask_voxel(1'b0);
    ask_voxel(1'b0);
    ask_voxel(1'b1);
    ask_voxel(1'b1);

    // Random phases. Most radii are small so that spheres run to completion
    // and the end-of-sphere flag and the empty tail are seen often; now and
    // then a large radius exercises wide coordinates. Each phase starts with
    // a restart, and rare restarts inside a phase drop the sphere in flight.
    target = requests_sent + RANDOM_REQS;
    phase  = 0;
    while (requests_sent < target) begin
      case ($urandom_range(9))
        0:       rad = 8'd255;
        1:       rad = RW'($urandom_range(255, 5));
        2:       rad = '0;
        3:       rad = 8'd1;
        default: rad = RW'($urandom_range(3, 2));
      endcase
      load_radius(rad);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 29; recv_stall_pct = 29;
        end
      endcase
      n = $urandom_range(110, 40);
      for (int k = 0; k < n && requests_sent < target; k++) begin
        // In odd phases the sender drains the block halfway through.
        if (k == n / 2 && phase % 2 == 1)
          wait_all_voxels();
        ask_voxel(k == 0 || $urandom_range(49) == 0);
      end
      phase++;
    end

    send_idle_pct = 0;
    wait_all_voxels();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sphere_voxel_generator.f @@
hw/rtl/svg_pkg.sv
hw/rtl/svg_walk.sv
hw/rtl/sphere_voxel_generator.sv
tb/sphere_voxel_checker.sv
tb/sphere_voxel_generator_test.sv
